// ===== sv/pete_pkg.sv =====
package pete_pkg;

   // Default sizes of the tables.
   localparam int EVENT_SLOTS = 16;
   localparam int PIN_SLOTS   = 16;

   // Ports at or beyond this count always sample as low.
   localparam int PORT_COUNT  = 64;

   // Field widths of the channels.
   localparam int KIND_W    = 3;
   localparam int PORT_W    = 6;
   localparam int REF_W     = 16;
   localparam int LEVELS_W  = 64;
   localparam int RKIND_W   = 2;
   localparam int PIN_OUT_W = 5;

   // Stored pin code wide enough for the largest pin table and its unregistered code.
   localparam int PIN_FIELD_W = 7;

   // Input item kinds.
   localparam logic [KIND_W-1:0] KIND_REGISTER = 3'd0;
   localparam logic [KIND_W-1:0] KIND_PUSH     = 3'd1;
   localparam logic [KIND_W-1:0] KIND_TICK     = 3'd2;
   localparam logic [KIND_W-1:0] KIND_FETCH    = 3'd3;
   localparam logic [KIND_W-1:0] KIND_FLUSH    = 3'd4;

   // Result kinds.
   localparam logic [RKIND_W-1:0] RKIND_DRIVE   = 2'd0;
   localparam logic [RKIND_W-1:0] RKIND_FETCHED = 2'd1;
   localparam logic [RKIND_W-1:0] RKIND_NONE    = 2'd2;

   typedef enum logic [1:0] {
      EVT_INACTIVE = 2'd0,
      EVT_PENDING  = 2'd1,
      EVT_ACTIVE   = 2'd2
   } evt_status_type;

   typedef struct packed {
      logic [REF_W-1:0]       evt_ref;
      logic [PORT_W-1:0]      port;
      logic [PIN_FIELD_W-1:0] pin;
      logic                   level;
      evt_status_type         status;
   } evt_entry_type;

   // Controls of one event cell: clear wins over load, load over shift.
   typedef struct packed {
      logic clear;
      logic load;
      logic shift;
   } evt_ctl_type;

   // Controls of one pin cell.
   typedef struct packed {
      logic clear;
      logic load;
   } pin_ctl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_TICK,
      ST_FETCH,
      ST_FETCH_OUT
   } pete_state_type;

endpackage

// ===== sv/pete_chan_if.sv =====
// Request channel: one beat carries one input item.
interface pete_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  kind;
   logic [5:0]  port;
   logic [15:0] event_ref;
   logic        direction;
   logic        level;
   logic [63:0] port_levels;

   modport source (output valid, kind, port, event_ref, direction, level, port_levels,
                   input ready);
   modport sink   (input valid, kind, port, event_ref, direction, level, port_levels,
                   output ready);
endinterface

// Response channel: one beat carries one result item.
interface pete_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  result_kind;
   logic [5:0]  out_port;
   logic        out_level;
   logic [15:0] out_ref;
   logic [4:0]  pin_index;
   logic        last;

   modport source (output valid, result_kind, out_port, out_level, out_ref, pin_index, last,
                   input ready);
   modport sink   (input valid, result_kind, out_port, out_level, out_ref, pin_index, last,
                   output ready);
endinterface

// ===== sv/pete_pin_cell.sv =====
module pete_pin_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  pete_pkg::pin_ctl_type ctl,
   input  logic [5:0]            load_port,
   input  logic [5:0]            probe_port,
   output logic                  hit,
   output logic                  valid
);
   import pete_pkg::*;

   logic [PORT_W-1:0] port_ff;
   logic              valid_ff;

   // The registered port; a cleared cell holds port zero and is not valid.
   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         port_ff  <= '0;
         valid_ff <= 1'b0;
      end else if (ctl.load) begin
         port_ff  <= load_port;
         valid_ff <= 1'b1;
      end
   end

   // Only a filled slot can answer a lookup.
   assign hit   = valid_ff && (port_ff == probe_port);
   assign valid = valid_ff;

endmodule

// ===== sv/pete_evt_cell.sv =====
module pete_evt_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  pete_pkg::evt_ctl_type   ctl,
   input  pete_pkg::evt_entry_type load_data,
   input  pete_pkg::evt_entry_type shift_data,
   output pete_pkg::evt_entry_type entry
);
   import pete_pkg::*;

   evt_entry_type entry_ff;

   // One ring slot: written by a push, or taking its neighbour's entry while the ring turns.
   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         entry_ff <= '{evt_ref: '0, port: '0, pin: '0, level: 1'b0, status: EVT_INACTIVE};
      end else if (ctl.load) begin
         entry_ff <= load_data;
      end else if (ctl.shift) begin
         entry_ff <= shift_data;
      end
   end

   assign entry = entry_ff;

endmodule

// ===== sv/pin_event_table_engine.sv =====
// Pin event table engine. Register, push and flush act as their beat is taken and give
// no result. Tick turns both event rings once around and fetch the input ring, one slot
// per cycle through the head cell, a tick stalling while a drive command waits on a full
// response register; each holds the request side until it is done, and fetch then
// holds it until its result is handed out to a free response register.
// Slots are visited in index order, so drive commands leave in slot order and a fetch
// returns the lowest active input slot. A new request beat is taken as soon as the engine
// is idle, even while its last result still waits in the response register.
module pin_event_table_engine #(
   parameter int EVENT_SLOTS = pete_pkg::EVENT_SLOTS,
   parameter int PIN_SLOTS   = pete_pkg::PIN_SLOTS
) (
   input logic       clock,
   input logic       reset,
   pete_req_if.sink   req_chan,
   pete_rsp_if.source rsp_chan
);
   import pete_pkg::*;

   localparam int SLOT_W = (EVENT_SLOTS > 1) ? $clog2(EVENT_SLOTS) : 1;
   localparam int PIN_W  = $clog2(PIN_SLOTS + 1);

   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(EVENT_SLOTS - 1);
   localparam logic [PIN_W-1:0]  NO_PIN    = PIN_W'(PIN_SLOTS);

   // Control state.
   pete_state_type    state_ff, state_in;
   logic [SLOT_W-1:0] scan_ff, scan_in;
   logic [SLOT_W-1:0] out_wi_ff, out_wi_in;
   logic [SLOT_W-1:0] in_wi_ff, in_wi_in;
   logic [PIN_W-1:0]  pin_count_ff, pin_count_in;
   logic              found_ff, found_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // Payload state.
   logic [LEVELS_W-1:0] levels_ff;
   evt_entry_type       fetch_ff;
   logic [RKIND_W-1:0]  rsp_kind_ff;
   logic [PORT_W-1:0]   rsp_port_ff;
   logic                rsp_level_ff;
   logic [REF_W-1:0]    rsp_ref_ff;
   logic [PIN_OUT_W-1:0] rsp_pin_ff;
   logic                rsp_last_ff;

   // Handshake and step controls.
   logic accept;
   logic rsp_free;
   logic tick_step;
   logic fetch_step;
   logic load_drive;
   logic load_fetch;

   // Cells.
   evt_entry_type out_q [EVENT_SLOTS];
   evt_entry_type in_q  [EVENT_SLOTS];
   evt_ctl_type   out_ctl [EVENT_SLOTS];
   evt_ctl_type   in_ctl  [EVENT_SLOTS];
   evt_entry_type out_head_mod, in_head_mod, push_entry;
   logic [EVENT_SLOTS-1:0] out_pend;
   logic          out_rest_pend;
   logic          head_sampled;

   pin_ctl_type   pin_ctl [PIN_SLOTS];
   logic [PIN_SLOTS-1:0] pin_hit, pin_valid;
   logic [PIN_W-1:0] pin_idx;
   logic          pin_found;

   logic is_register, is_push, is_tick, is_fetch, is_flush;

   assign accept      = req_chan.valid && req_chan.ready;
   assign rsp_free    = !rsp_valid_ff || rsp_chan.ready;
   assign is_register = accept && (req_chan.kind == KIND_REGISTER);
   assign is_push     = accept && (req_chan.kind == KIND_PUSH);
   assign is_tick     = accept && (req_chan.kind == KIND_TICK);
   assign is_fetch    = accept && (req_chan.kind == KIND_FETCH);
   assign is_flush    = accept && (req_chan.kind == KIND_FLUSH);

   // Pin table lookup: ports in the table are unique, so the hits can be merged by OR.
   always_comb begin
      pin_idx   = '0;
      pin_found = |pin_hit;
      for (int i = 0; i < PIN_SLOTS; i++) begin
         if (pin_hit[i]) begin
            pin_idx = pin_idx | PIN_W'(i);
         end
      end
      if (!pin_found) begin
         pin_idx = NO_PIN;
      end
   end

   // Pin cells: a new port goes into the first free slot while there is one.
   genvar gp;
   generate
      for (gp = 0; gp < PIN_SLOTS; gp++) begin : g_pin
         always_comb begin
            pin_ctl[gp].clear = is_flush;
            pin_ctl[gp].load  = is_register && !pin_found &&
                                (pin_count_ff == PIN_W'(gp));
         end
         pete_pin_cell u_pin (
            .clock      (clock),
            .reset      (reset),
            .ctl        (pin_ctl[gp]),
            .load_port  (req_chan.port),
            .probe_port (req_chan.port),
            .hit        (pin_hit[gp]),
            .valid      (pin_valid[gp])
         );
      end
   endgenerate

   // Entry written by a push.
   always_comb begin
      push_entry.evt_ref = req_chan.event_ref;
      push_entry.port    = req_chan.port;
      push_entry.pin     = PIN_FIELD_W'(pin_idx);
      push_entry.level   = req_chan.level;
      push_entry.status  = EVT_PENDING;
   end

   // Pending flags of the output ring; the head is excluded from the look-ahead.
   always_comb begin
      out_rest_pend = 1'b0;
      for (int k = 0; k < EVENT_SLOTS; k++) begin
         out_pend[k] = (out_q[k].status == EVT_PENDING);
      end
      for (int k = 1; k < EVENT_SLOTS; k++) begin
         out_rest_pend = out_rest_pend | out_pend[k];
      end
   end

   // Sampled level of the head input event's port.
   assign head_sampled = ({1'b0, in_q[0].port} < 7'(PORT_COUNT)) &&
                         levels_ff[in_q[0].port];

   // Head cell updates as each slot passes it.
   always_comb begin
      out_head_mod = out_q[0];
      if (out_pend[0]) begin
         out_head_mod.status = EVT_INACTIVE;
      end
      in_head_mod = in_q[0];
      if (state_ff == ST_TICK) begin
         if (in_q[0].status == EVT_PENDING && head_sampled == in_q[0].level) begin
            in_head_mod.status = EVT_ACTIVE;
         end
      end else if (!found_ff && in_q[0].status == EVT_ACTIVE) begin
         in_head_mod.status = EVT_INACTIVE;
      end
   end

   // Event rings: each cell takes from its upper neighbour, the top cell from the head.
   genvar ge;
   generate
      for (ge = 0; ge < EVENT_SLOTS; ge++) begin : g_evt
         evt_entry_type out_next, in_next;
         if (ge == EVENT_SLOTS - 1) begin : g_top
            assign out_next = out_head_mod;
            assign in_next  = in_head_mod;
         end else begin : g_mid
            assign out_next = out_q[ge+1];
            assign in_next  = in_q[ge+1];
         end
         always_comb begin
            out_ctl[ge].clear = is_flush;
            out_ctl[ge].load  = is_push && !req_chan.direction &&
                                (out_wi_ff == SLOT_W'(ge));
            out_ctl[ge].shift = tick_step;
            in_ctl[ge].clear  = is_flush;
            in_ctl[ge].load   = is_push && req_chan.direction &&
                                (in_wi_ff == SLOT_W'(ge));
            in_ctl[ge].shift  = tick_step || fetch_step;
         end
         pete_evt_cell u_out (
            .clock      (clock),
            .reset      (reset),
            .ctl        (out_ctl[ge]),
            .load_data  (push_entry),
            .shift_data (out_next),
            .entry      (out_q[ge])
         );
         pete_evt_cell u_in (
            .clock      (clock),
            .reset      (reset),
            .ctl        (in_ctl[ge]),
            .load_data  (push_entry),
            .shift_data (in_next),
            .entry      (in_q[ge])
         );
      end
   endgenerate

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (is_tick) begin
               state_in = ST_TICK;
            end else if (is_fetch) begin
               state_in = ST_FETCH;
            end
         end
         ST_TICK: begin
            if (tick_step && scan_ff == LAST_SLOT) begin
               state_in = ST_IDLE;
            end
         end
         ST_FETCH: begin
            if (scan_ff == LAST_SLOT) begin
               state_in = ST_FETCH_OUT;
            end
         end
         ST_FETCH_OUT: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs of the state machine.
   always_comb begin
      req_chan.ready = 1'b0;
      tick_step      = 1'b0;
      fetch_step     = 1'b0;
      load_drive     = 1'b0;
      load_fetch     = 1'b0;
      unique case (state_ff)
         ST_IDLE:      req_chan.ready = 1'b1;
         ST_TICK: begin
            tick_step  = !out_pend[0] || rsp_free;
            load_drive = out_pend[0] && rsp_free;
         end
         ST_FETCH:     fetch_step = 1'b1;
         ST_FETCH_OUT: load_fetch = rsp_free;
         default: ;
      endcase
   end

   // Scan counter, write indexes, pin count and fetch capture.
   always_comb begin
      scan_in      = scan_ff;
      out_wi_in    = out_wi_ff;
      in_wi_in     = in_wi_ff;
      pin_count_in = pin_count_ff;
      found_in     = found_ff;
      if (tick_step || fetch_step) begin
         scan_in = (scan_ff == LAST_SLOT) ? '0 : scan_ff + 1'b1;
      end
      if (is_push) begin
         if (req_chan.direction) begin
            in_wi_in  = (in_wi_ff == LAST_SLOT) ? '0 : in_wi_ff + 1'b1;
         end else begin
            out_wi_in = (out_wi_ff == LAST_SLOT) ? '0 : out_wi_ff + 1'b1;
         end
      end
      if (is_register && !pin_found && pin_count_ff != NO_PIN) begin
         pin_count_in = pin_count_ff + 1'b1;
      end
      if (is_fetch) begin
         found_in = 1'b0;
      end else if (fetch_step && in_q[0].status == EVT_ACTIVE) begin
         found_in = 1'b1;
      end
      if (is_flush) begin
         out_wi_in    = '0;
         in_wi_in     = '0;
         pin_count_in = '0;
      end
   end

   // Response register valid flag.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_drive || load_fetch) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         scan_ff      <= '0;
         out_wi_ff    <= '0;
         in_wi_ff     <= '0;
         pin_count_ff <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scan_ff      <= scan_in;
         out_wi_ff    <= out_wi_in;
         in_wi_ff     <= in_wi_in;
         pin_count_ff <= pin_count_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers: sampled levels, the fetched entry and the response beat.
   always_ff @(posedge clock) begin
      if (is_tick) begin
         levels_ff <= req_chan.port_levels;
      end
      if (fetch_step && !found_ff && in_q[0].status == EVT_ACTIVE) begin
         fetch_ff <= in_q[0];
      end
      if (load_drive) begin
         rsp_kind_ff  <= RKIND_DRIVE;
         rsp_port_ff  <= out_q[0].port;
         rsp_level_ff <= out_q[0].level;
         rsp_ref_ff   <= out_q[0].evt_ref;
         rsp_pin_ff   <= PIN_OUT_W'(out_q[0].pin);
         rsp_last_ff  <= !out_rest_pend;
      end else if (load_fetch) begin
         rsp_kind_ff  <= found_ff ? RKIND_FETCHED : RKIND_NONE;
         rsp_port_ff  <= found_ff ? fetch_ff.port : '0;
         rsp_level_ff <= found_ff ? fetch_ff.level : 1'b0;
         rsp_ref_ff   <= found_ff ? fetch_ff.evt_ref : '0;
         rsp_pin_ff   <= found_ff ? PIN_OUT_W'(fetch_ff.pin) : '0;
         rsp_last_ff  <= 1'b1;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.result_kind = rsp_kind_ff;
   assign rsp_chan.out_port    = rsp_port_ff;
   assign rsp_chan.out_level   = rsp_level_ff;
   assign rsp_chan.out_ref     = rsp_ref_ff;
   assign rsp_chan.pin_index   = rsp_pin_ff;
   assign rsp_chan.last        = rsp_last_ff;

   // A finished tick leaves no output event pending.
   a_tick_drains: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TICK && state_in == ST_IDLE) |=> !(|out_pend))
      else $error("output event still pending after tick");

   // The rings sit aligned whenever the engine is idle.
   a_scan_aligned: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (scan_ff == '0))
      else $error("scan counter not at slot zero while idle");

   // Filled pin slots match the pin count.
   a_pin_count: assert property (@(posedge clock) disable iff (reset)
      $countones(pin_valid) == int'(pin_count_ff))
      else $error("pin count disagrees with filled pin slots");

   // A drive or fetch result is only loaded when the response register can take it.
   a_rsp_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_chan.ready) |-> !(load_drive || load_fetch))
      else $error("response beat overwritten before it was taken");

endmodule

// ===== test/tb_pin_event_table_engine.sv =====
module tb_pin_event_table_engine;
   import pete_pkg::*;

   // One request beat and one response beat, as the predictor sees them.
   typedef struct packed {
      logic [KIND_W-1:0]   kind;
      logic [PORT_W-1:0]   port;
      logic [REF_W-1:0]    evt_ref;
      logic                direction;
      logic                level;
      logic [LEVELS_W-1:0] port_levels;
   } pin_cmd_type;

   typedef struct packed {
      logic [RKIND_W-1:0]   kind;
      logic [PORT_W-1:0]    port;
      logic                 level;
      logic [REF_W-1:0]     evt_ref;
      logic [PIN_OUT_W-1:0] pin;
      logic                 last;
   } pin_result_type;

   typedef struct {
      logic [REF_W-1:0]     evt_ref;
      logic [PORT_W-1:0]    port;
      logic [PIN_OUT_W-1:0] pin;
      logic                 level;
      evt_status_type       status;
   } ring_slot_type;

   localparam logic [PIN_OUT_W-1:0] NO_PIN = PIN_OUT_W'(PIN_SLOTS);
   localparam logic [KIND_W-1:0] KIND_LAST = {KIND_W{1'b1}};

   logic clock;
   logic reset;

   pete_req_if req_bus ();
   pete_rsp_if rsp_bus ();

   pin_event_table_engine u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // Shadow copy of the engine's tables.
   logic [PORT_W-1:0] pin_table [PIN_SLOTS];
   int                pin_used;
   ring_slot_type     out_ring [EVENT_SLOTS];
   ring_slot_type     in_ring [EVENT_SLOTS];
   int                out_wr;
   int                in_wr;

   pin_result_type results_owed [$];

   int fail_count   = 0;
   int cmds_sent    = 0;
   int cmds_ignored = 0;
   int drives_seen  = 0;
   int fetches_seen = 0;
   int empties_seen = 0;
   int burst_left   = 0;
   bit steady_sender = 0;
   int rx_cycle     = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Clears the shadow tables, as reset and flush do.
   function automatic void clear_pin_state();
      for (int i = 0; i < PIN_SLOTS; i++) pin_table[i] = '0;
      for (int i = 0; i < EVENT_SLOTS; i++) begin
         out_ring[i] = '{evt_ref: '0, port: '0, pin: '0, level: 1'b0, status: EVT_INACTIVE};
         in_ring[i]  = '{evt_ref: '0, port: '0, pin: '0, level: 1'b0, status: EVT_INACTIVE};
      end
      pin_used = 0;
      out_wr   = 0;
      in_wr    = 0;
   endfunction

   function automatic logic [PIN_OUT_W-1:0] find_pin(logic [PORT_W-1:0] port);
      for (int i = 0; i < pin_used; i++)
         if (pin_table[i] == port) return PIN_OUT_W'(i);
      return NO_PIN;
   endfunction

   // Applies one accepted command to the shadow tables and queues the results it owes.
   function automatic void apply_pin_cmd(pin_cmd_type cmd);
      ring_slot_type  slot;
      pin_result_type res;
      int             mark;
      bit             found;
      mark  = results_owed.size();
      found = 0;
      case (cmd.kind)
         KIND_REGISTER: begin
            if (find_pin(cmd.port) == NO_PIN && pin_used < PIN_SLOTS) begin
               pin_table[pin_used] = cmd.port;
               pin_used++;
            end
         end
         KIND_PUSH: begin
            slot = '{evt_ref: cmd.evt_ref, port: cmd.port, pin: find_pin(cmd.port),
                     level: cmd.level, status: EVT_PENDING};
            if (cmd.direction) begin
               in_ring[in_wr] = slot;
               in_wr = (in_wr + 1) % EVENT_SLOTS;
            end else begin
               out_ring[out_wr] = slot;
               out_wr = (out_wr + 1) % EVENT_SLOTS;
            end
         end
         KIND_TICK: begin
            // Every pending output event becomes a drive command, in slot order.
            for (int i = 0; i < EVENT_SLOTS; i++) begin
               if (out_ring[i].status == EVT_PENDING) begin
                  res = '{kind: RKIND_DRIVE, port: out_ring[i].port, level: out_ring[i].level,
                          evt_ref: out_ring[i].evt_ref, pin: out_ring[i].pin, last: 1'b0};
                  results_owed.push_back(res);
                  out_ring[i].status = EVT_INACTIVE;
               end
            end
            // Pending input events whose level shows become active.
            for (int i = 0; i < EVENT_SLOTS; i++) begin
               if (in_ring[i].status == EVT_PENDING &&
                   ((in_ring[i].port < PORT_COUNT) && cmd.port_levels[in_ring[i].port])
                   == in_ring[i].level)
                  in_ring[i].status = EVT_ACTIVE;
            end
         end
         KIND_FETCH: begin
            for (int i = 0; i < EVENT_SLOTS && !found; i++) begin
               if (in_ring[i].status == EVT_ACTIVE) begin
                  res = '{kind: RKIND_FETCHED, port: in_ring[i].port, level: in_ring[i].level,
                          evt_ref: in_ring[i].evt_ref, pin: in_ring[i].pin, last: 1'b0};
                  results_owed.push_back(res);
                  in_ring[i].status = EVT_INACTIVE;
                  found = 1;
               end
            end
            if (!found) begin
               res = '{kind: RKIND_NONE, port: '0, level: 1'b0, evt_ref: '0, pin: '0,
                       last: 1'b0};
               results_owed.push_back(res);
            end
         end
         KIND_FLUSH: clear_pin_state();
         default: ;
      endcase
      if (results_owed.size() > mark) results_owed[results_owed.size() - 1].last = 1'b1;
   endfunction

   function automatic pin_cmd_type make_cmd(logic [KIND_W-1:0] kind, logic [PORT_W-1:0] port,
                                            logic [REF_W-1:0] evt_ref, logic direction,
                                            logic level, logic [LEVELS_W-1:0] port_levels);
      return '{kind: kind, port: port, evt_ref: evt_ref, direction: direction,
               level: level, port_levels: port_levels};
   endfunction

   // Sends one beat, opening a new burst when the current one is spent, after a random gap unless the sender is steady.
   task automatic send_cmd(input pin_cmd_type cmd);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 10);
         if (!steady_sender) begin
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
               req_bus.valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
      end
      burst_left--;
      req_bus.valid       <= 1'b1;
      req_bus.kind        <= cmd.kind;
      req_bus.port        <= cmd.port;
      req_bus.event_ref   <= cmd.evt_ref;
      req_bus.direction   <= cmd.direction;
      req_bus.level       <= cmd.level;
      req_bus.port_levels <= cmd.port_levels;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      apply_pin_cmd(cmd);
      if (cmd.kind <= KIND_FLUSH) cmds_sent++;
      else cmds_ignored++;
   endtask

   // Drops valid and waits until every owed result has arrived, then a little longer.
   task automatic settle_results();
      req_bus.valid <= 1'b0;
      burst_left = 0;
      while (results_owed.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   // Response side: ready follows one of four stall patterns, taken in turn.
   always @(posedge clock) begin
      case ((rx_cycle / 97) % 4)
         0: rsp_bus.ready <= 1'b1;
         1: rsp_bus.ready <= ($urandom_range(0, 3) != 0);
         2: rsp_bus.ready <= ((rx_cycle % 23) < 8);
         default: rsp_bus.ready <= $urandom_range(0, 1);
      endcase
      rx_cycle++;
   end

   task automatic check_field(input string what, input logic [15:0] want, input logic [15:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
         fail_count++;
      end
   endtask

   // Every accepted result beat is held against the oldest owed result.
   always @(posedge clock) begin
      pin_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (results_owed.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual kind %0d port %0d",
                     $time, rsp_bus.result_kind, rsp_bus.out_port);
            fail_count++;
         end else begin
            want = results_owed.pop_front();
            check_field("result_kind", want.kind, rsp_bus.result_kind);
            check_field("out_port", want.port, rsp_bus.out_port);
            check_field("out_level", want.level, rsp_bus.out_level);
            check_field("out_ref", want.evt_ref, rsp_bus.out_ref);
            check_field("pin_index", want.pin, rsp_bus.pin_index);
            check_field("last", want.last, rsp_bus.last);
            case (want.kind)
               RKIND_DRIVE:   drives_seen++;
               RKIND_FETCHED: fetches_seen++;
               default:       empties_seen++;
            endcase
         end
      end
   end

   // Port 0 and port 63 are registered; a second registration of port 0 is ignored.
   task automatic test_pin_registration();
      send_cmd(make_cmd(KIND_REGISTER, 6'd0, 16'h0, 1'b0, 1'b0, '0));
      send_cmd(make_cmd(KIND_REGISTER, 6'd63, 16'hffff, 1'b1, 1'b1, '1));
      send_cmd(make_cmd(KIND_REGISTER, 6'd0, 16'h5a5a, 1'b0, 1'b1, '0));
   endtask

   // Output events of a registered and an unregistered port are driven by one tick.
   task automatic test_output_drive();
      send_cmd(make_cmd(KIND_PUSH, 6'd63, 16'hffff, 1'b0, 1'b1, '0));
      send_cmd(make_cmd(KIND_PUSH, 6'd5, 16'h0000, 1'b0, 1'b0, '0));
      send_cmd(make_cmd(KIND_TICK, 6'd0, 16'h0, 1'b0, 1'b0, '0));
   endtask

   // Input events become active when their level is sampled and are fetched in slot order.
   task automatic test_input_watch();
      send_cmd(make_cmd(KIND_PUSH, 6'd0, 16'h1234, 1'b1, 1'b0, '0));
      send_cmd(make_cmd(KIND_PUSH, 6'd63, 16'hfffe, 1'b1, 1'b1, '0));
      send_cmd(make_cmd(KIND_PUSH, 6'd63, 16'h0001, 1'b1, 1'b0, '0));
      send_cmd(make_cmd(KIND_TICK, 6'd0, 16'h0, 1'b0, 1'b0, 64'h8000_0000_0000_0000));
      send_cmd(make_cmd(KIND_FETCH, 6'd0, 16'h0, 1'b0, 1'b0, '0));
      send_cmd(make_cmd(KIND_FETCH, 6'd0, 16'h0, 1'b0, 1'b0, '0));
      send_cmd(make_cmd(KIND_FETCH, 6'd0, 16'h0, 1'b0, 1'b0, '0));
      send_cmd(make_cmd(KIND_TICK, 6'd0, 16'h0, 1'b0, 1'b0, '1));
      send_cmd(make_cmd(KIND_TICK, 6'd0, 16'h0, 1'b0, 1'b0, '0));
      send_cmd(make_cmd(KIND_FETCH, 6'd0, 16'h0, 1'b0, 1'b0, '0));
   endtask

   // Kinds beyond flush must be ignored.
   task automatic test_unused_kinds();
      for (int k = KIND_FLUSH + 1; k <= KIND_LAST; k++)
         send_cmd(make_cmd(KIND_W'(k), 6'($urandom_range(0, 63)), 16'($urandom()),
                           1'($urandom()), 1'($urandom()), {$urandom(), $urandom()}));
   endtask

   // A flush empties the rings and the pin table.
   task automatic test_flush();
      send_cmd(make_cmd(KIND_PUSH, 6'd7, 16'h7777, 1'b0, 1'b1, '0));
      send_cmd(make_cmd(KIND_PUSH, 6'd8, 16'h8888, 1'b1, 1'b0, '0));
      send_cmd(make_cmd(KIND_FLUSH, 6'd0, 16'h0, 1'b0, 1'b0, '0));
      send_cmd(make_cmd(KIND_TICK, 6'd0, 16'h0, 1'b0, 1'b0, '0));
      send_cmd(make_cmd(KIND_FETCH, 6'd0, 16'h0, 1'b0, 1'b0, '0));
      send_cmd(make_cmd(KIND_REGISTER, 6'd63, 16'h0, 1'b0, 1'b0, '0));
   endtask

   // Ports mostly come from a small pool so that lookups hit and the table fills.
   function automatic logic [PORT_W-1:0] pick_port();
      logic [PORT_W-1:0] p;
      if ($urandom_range(0, 9) < 3) return PORT_W'($urandom_range(0, 63));
      p = PORT_W'($urandom_range(0, 23));
      if ($urandom_range(0, 1)) p = p + 6'd40;
      return p;
   endfunction

   function automatic logic [LEVELS_W-1:0] pick_levels();
      case ($urandom_range(0, 3))
         0: return '0;
         1: return '1;
         default: return {$urandom(), $urandom()};
      endcase
   endfunction

   // Mostly rounds of register, push, tick and fetch, with noise and the odd flush between.
   task automatic test_random_traffic(input int target);
      int start;
      int count;
      int pick;
      start = cmds_sent;
      while (cmds_sent - start < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 12) begin
            count = $urandom_range(1, 4);
            repeat (count)
               send_cmd(make_cmd(KIND_W'($urandom_range(0, KIND_LAST)),
                                 PORT_W'($urandom_range(0, 63)), REF_W'($urandom()),
                                 1'($urandom()), 1'($urandom()), {$urandom(), $urandom()}));
         end else if (pick < 18) begin
            send_cmd(make_cmd(KIND_FLUSH, pick_port(), REF_W'($urandom()), 1'($urandom()),
                              1'($urandom()), {$urandom(), $urandom()}));
         end else begin
            steady_sender = ($urandom_range(0, 3) == 0);
            count = $urandom_range(0, 3);
            repeat (count)
               send_cmd(make_cmd(KIND_REGISTER, pick_port(), REF_W'($urandom()),
                                 1'($urandom()), 1'($urandom()), {$urandom(), $urandom()}));
            count = ($urandom_range(0, 5) == 0) ? $urandom_range(14, 20) : $urandom_range(0, 5);
            repeat (count)
               send_cmd(make_cmd(KIND_PUSH, pick_port(), REF_W'($urandom()), 1'b0,
                                 1'($urandom()), {$urandom(), $urandom()}));
            count = ($urandom_range(0, 5) == 0) ? $urandom_range(14, 20) : $urandom_range(0, 4);
            repeat (count)
               send_cmd(make_cmd(KIND_PUSH, pick_port(), REF_W'($urandom()), 1'b1,
                                 1'($urandom()), {$urandom(), $urandom()}));
            count = $urandom_range(1, 2);
            repeat (count)
               send_cmd(make_cmd(KIND_TICK, PORT_W'($urandom()), REF_W'($urandom()),
                                 1'($urandom()), 1'($urandom()), pick_levels()));
            count = $urandom_range(0, 4);
            repeat (count)
               send_cmd(make_cmd(KIND_FETCH, PORT_W'($urandom()), REF_W'($urandom()),
                                 1'($urandom()), 1'($urandom()), {$urandom(), $urandom()}));
            steady_sender = 0;
         end
      end
   endtask

   initial begin
      reset               <= 1'b1;
      req_bus.valid       <= 1'b0;
      req_bus.kind        <= KIND_REGISTER;
      req_bus.port        <= '0;
      req_bus.event_ref   <= '0;
      req_bus.direction   <= 1'b0;
      req_bus.level       <= 1'b0;
      req_bus.port_levels <= '0;
      clear_pin_state();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_pin_registration();
      test_output_drive();
      test_input_watch();
      test_unused_kinds();
      test_flush();
      test_random_traffic(440);
      settle_results();

      $display("Sent %0d commands and %0d of unused kinds.", cmds_sent, cmds_ignored);
      $display("Checked %0d drive commands, %0d fetched events and %0d empty fetches.",
               drives_seen, fetches_seen, empties_seen);
      if (fail_count == 0) begin
         $display("tb_pin_event_table_engine passed");
      end else begin
         $display("tb_pin_event_table_engine failed");
      end
      $finish;
   end

   // Guard against a hung handshake.
   initial begin
      #20000000;
      $display("%0t: timed out with %0d results still owed", $time, results_owed.size());
      $display("tb_pin_event_table_engine failed");
      $finish;
   end

endmodule

// ===== sim.f =====
sv/pete_pkg.sv
sv/pete_chan_if.sv
sv/pete_pin_cell.sv
sv/pete_evt_cell.sv
sv/pin_event_table_engine.sv
test/tb_pin_event_table_engine.sv
